// File: src/hms_pkg.sv
// Shared types and constants for the hybrid merge/insertion sorter.
// Used by hms_ctrl, hms_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hms_pkg;

   localparam int DATA_W = 32;

   // Source of the word written into either memory.
   typedef enum logic [1:0] {
      WR_IN,
      WR_RD0,
      WR_RD1,
      WR_KEY
   } wr_src_type;

   typedef struct packed {
      logic       wr_en;
      logic       wr_to_b;
      wr_src_type wr_src;
      logic       rd_from_b;
      logic       key_load;
      logic       out_load;
      logic       out_last;
      logic       out_overflow;
   } dp_cmd_type;

   typedef struct packed {
      logic rd0_gt_key;
      logic rd0_le_rd1;
   } dp_status_type;

endpackage

`default_nettype wire

// File: src/hybrid_merge_insertion_sorter.sv
// Top level of the hybrid merge/insertion sorter: joins hms_ctrl and
// hms_datapath. Depends on hms_pkg.
//
// Usage: signed 32-bit words arrive on the req_ channel, one per cycle while
// the block is loading; req_tlast marks the final word of a batch. Up to
// MAX_ELEMENTS words are kept; later words are dropped and the batch is
// flagged. After the final word req_tready falls while the batch is sorted:
// runs of r = INSERTION_CUTOFF-1 words are insertion sorted, then bottom-up
// merge passes follow, ceil(log2(N/r)) of them for N words. Each merged word
// is read through the two memory read ports into registers and then
// written. The burst then leaves on rsp_ in ascending order; each word is
// read from the store only once the result register has been taken, with
// rsp_tlast on the final word and rsp_tuser set on every word if any
// element was dropped. A stalled receiver holds the result register and
// halts the burst; nothing is lost. Loading of the next batch starts as
// soon as the final result word sits in the result register. Reset empties
// the batch and clears the overflow flag and rsp_tvalid.
`timescale 1ns / 1ps
`default_nettype none

module hybrid_merge_insertion_sorter #(
   parameter int MAX_ELEMENTS     = 64,
   parameter int INSERTION_CUTOFF = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] element_value
   input  wire logic        req_tlast,   // final_element
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] sorted_value
   output logic             rsp_tlast,   // last_of_batch
   output logic [0:0]       rsp_tuser    // [0] overflow
);

   localparam int AW = $clog2(MAX_ELEMENTS);

   hms_pkg::dp_cmd_type    cmd;
   hms_pkg::dp_status_type status;
   logic [AW-1:0]          wr_addr;
   logic [AW-1:0]          rd_addr0;
   logic [AW-1:0]          rd_addr1;
   logic                   out_overflow;

   hms_ctrl #(
      .MAX_ELEMENTS     (MAX_ELEMENTS),
      .INSERTION_CUTOFF (INSERTION_CUTOFF)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd),
      .wr_addr    (wr_addr),
      .rd_addr0   (rd_addr0),
      .rd_addr1   (rd_addr1)
   );

   hms_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .wr_addr      (wr_addr),
      .rd_addr0     (rd_addr0),
      .rd_addr1     (rd_addr1),
      .in_value     (req_tdata),
      .status       (status),
      .out_value    (rsp_tdata),
      .out_last     (rsp_tlast),
      .out_overflow (out_overflow)
   );

   assign rsp_tuser = out_overflow;

endmodule

`default_nettype wire

// File: src/hms_datapath.sv
// Datapath of the sorter: element store, merge buffer, key register,
// signed comparators and the result register. Depends on hms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hms_datapath #(
   parameter int MAX_ELEMENTS = 64,
   localparam int AW = $clog2(MAX_ELEMENTS)
) (
   input  wire logic                        clock,
   input  wire hms_pkg::dp_cmd_type         cmd,
   input  wire logic [AW-1:0]               wr_addr,
   input  wire logic [AW-1:0]               rd_addr0,
   input  wire logic [AW-1:0]               rd_addr1,
   input  wire logic [hms_pkg::DATA_W-1:0]  in_value,
   output hms_pkg::dp_status_type           status,
   output logic [hms_pkg::DATA_W-1:0]       out_value,
   output logic                             out_last,
   output logic                             out_overflow
);

   logic [hms_pkg::DATA_W-1:0] mem_a [MAX_ELEMENTS];
   logic [hms_pkg::DATA_W-1:0] mem_b [MAX_ELEMENTS];

   logic [hms_pkg::DATA_W-1:0] rd0_ff;
   logic [hms_pkg::DATA_W-1:0] rd1_ff;
   logic [hms_pkg::DATA_W-1:0] key_ff;
   logic [hms_pkg::DATA_W-1:0] out_value_ff;
   logic                       out_last_ff;
   logic                       out_overflow_ff;
   logic [hms_pkg::DATA_W-1:0] wr_data;

   always_comb begin
      unique case (cmd.wr_src)
         hms_pkg::WR_IN:  wr_data = in_value;
         hms_pkg::WR_RD0: wr_data = rd0_ff;
         hms_pkg::WR_RD1: wr_data = rd1_ff;
         hms_pkg::WR_KEY: wr_data = key_ff;
         default:         wr_data = in_value;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && !cmd.wr_to_b) begin
         mem_a[wr_addr] <= wr_data;
      end
      if (cmd.wr_en && cmd.wr_to_b) begin
         mem_b[wr_addr] <= wr_data;
      end
      rd0_ff <= cmd.rd_from_b ? mem_b[rd_addr0] : mem_a[rd_addr0];
      rd1_ff <= cmd.rd_from_b ? mem_b[rd_addr1] : mem_a[rd_addr1];
   end

   always_ff @(posedge clock) begin
      if (cmd.key_load) begin
         key_ff <= rd0_ff;
      end
      if (cmd.out_load) begin
         out_value_ff    <= rd0_ff;
         out_last_ff     <= cmd.out_last;
         out_overflow_ff <= cmd.out_overflow;
      end
   end

   assign status.rd0_gt_key = $signed(rd0_ff) > $signed(key_ff);
   assign status.rd0_le_rd1 = $signed(rd0_ff) <= $signed(rd1_ff);

   assign out_value    = out_value_ff;
   assign out_last     = out_last_ff;
   assign out_overflow = out_overflow_ff;

endmodule

`default_nettype wire

// File: src/hms_ctrl.sv
// Sequencer of the sorter: batch loading, insertion runs, bottom-up merge
// passes and the result burst. Drives hms_datapath; depends on hms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hms_ctrl #(
   parameter int MAX_ELEMENTS     = 64,
   parameter int INSERTION_CUTOFF = 32,
   localparam int AW = $clog2(MAX_ELEMENTS)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_tlast,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire hms_pkg::dp_status_type status,
   output hms_pkg::dp_cmd_type       cmd,
   output logic [AW-1:0]             wr_addr,
   output logic [AW-1:0]             rd_addr0,
   output logic [AW-1:0]             rd_addr1
);

   localparam int CW      = $clog2(MAX_ELEMENTS + 1);
   localparam int XW      = CW + 2;
   localparam int RUN_RAW = (INSERTION_CUTOFF > 1) ? INSERTION_CUTOFF - 1 : 1;
   localparam int RUN     = (RUN_RAW > MAX_ELEMENTS) ? MAX_ELEMENTS : RUN_RAW;
   localparam logic [XW-1:0] RUN_X = XW'(RUN);
   localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_INS_RUN,
      ST_INS_NEXT,
      ST_INS_KEY,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_MRG_PASS,
      ST_MRG_PAIR,
      ST_MRG_RD,
      ST_MRG_WR,
      ST_EM_RD,
      ST_EM_LD
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            ovf_ff, ovf_in;
   logic [CW-1:0]   n_ff, n_in;
   logic [XW-1:0]   lo_ff, lo_in;
   logic [XW-1:0]   width_ff, width_in;
   logic [CW-1:0]   hi_ff, hi_in;
   logic [CW-1:0]   mid_ff, mid_in;
   logic [CW-1:0]   i_ff, i_in;
   logic [CW-1:0]   j_ff, j_in;
   logic [CW-1:0]   a_ff, a_in;
   logic [CW-1:0]   b_ff, b_in;
   logic [CW-1:0]   k_ff, k_in;
   logic            src_b_ff, src_b_in;
   logic            out_valid_ff, out_valid_in;

   logic [XW-1:0]   n_x;
   logic [CW-1:0]   j_m1;
   logic [CW-1:0]   j_m2;
   logic [CW-1:0]   k_p1;
   logic            take_a;

   function automatic logic [XW-1:0] min_x(input logic [XW-1:0] p, input logic [XW-1:0] q);
      return (p < q) ? p : q;
   endfunction

   assign n_x    = XW'(n_ff);
   assign j_m1   = j_ff - CW'(1);
   assign j_m2   = j_ff - CW'(2);
   assign k_p1   = k_ff + CW'(1);
   assign take_a = (a_ff < mid_ff) && ((b_ff >= hi_ff) || status.rd0_le_rd1);

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      n_in         = n_ff;
      lo_in        = lo_ff;
      width_in     = width_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      k_in         = k_ff;
      src_b_in     = src_b_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      cmd          = '0;
      wr_addr      = '0;
      rd_addr0     = '0;
      rd_addr1     = '0;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_tvalid) begin
               if (count_ff < MAX_C) begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_src = hms_pkg::WR_IN;
                  wr_addr    = count_ff[AW-1:0];
                  count_in   = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  n_in     = (count_ff < MAX_C) ? count_ff + CW'(1) : count_ff;
                  lo_in    = '0;
                  state_in = ST_INS_RUN;
               end
            end
         end
         ST_INS_RUN: begin
            if (lo_ff >= n_x) begin
               width_in = RUN_X;
               src_b_in = 1'b0;
               state_in = ST_MRG_PASS;
            end else begin
               hi_in    = CW'(min_x(lo_ff + RUN_X, n_x));
               i_in     = CW'(lo_ff + XW'(1));
               state_in = ST_INS_NEXT;
            end
         end
         ST_INS_NEXT: begin
            if (i_ff >= hi_ff) begin
               lo_in    = lo_ff + RUN_X;
               state_in = ST_INS_RUN;
            end else begin
               rd_addr0 = i_ff[AW-1:0];
               j_in     = i_ff;
               state_in = ST_INS_KEY;
            end
         end
         ST_INS_KEY: begin
            cmd.key_load = 1'b1;
            rd_addr0     = j_m1[AW-1:0];
            state_in     = ST_INS_CMP;
         end
         ST_INS_CMP: begin
            // Shift the larger neighbour up one place, or drop the key in.
            cmd.wr_en = 1'b1;
            wr_addr   = j_ff[AW-1:0];
            if (status.rd0_gt_key) begin
               cmd.wr_src = hms_pkg::WR_RD0;
               j_in       = j_m1;
               rd_addr0   = j_m2[AW-1:0];
               if (XW'(j_m1) == lo_ff) begin
                  state_in = ST_INS_PUT;
               end
            end else begin
               cmd.wr_src = hms_pkg::WR_KEY;
               i_in       = i_ff + CW'(1);
               state_in   = ST_INS_NEXT;
            end
         end
         ST_INS_PUT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = hms_pkg::WR_KEY;
            wr_addr    = lo_ff[AW-1:0];
            i_in       = i_ff + CW'(1);
            state_in   = ST_INS_NEXT;
         end
         ST_MRG_PASS: begin
            if (width_ff >= n_x) begin
               k_in     = '0;
               state_in = ST_EM_RD;
            end else begin
               lo_in    = '0;
               state_in = ST_MRG_PAIR;
            end
         end
         ST_MRG_PAIR: begin
            // A pair whose right run is empty is copied across unchanged.
            if (lo_ff >= n_x) begin
               width_in = width_ff << 1;
               src_b_in = !src_b_ff;
               state_in = ST_MRG_PASS;
            end else begin
               mid_in   = CW'(min_x(lo_ff + width_ff, n_x));
               hi_in    = CW'(min_x(lo_ff + (width_ff << 1), n_x));
               a_in     = CW'(lo_ff);
               b_in     = CW'(min_x(lo_ff + width_ff, n_x));
               k_in     = CW'(lo_ff);
               state_in = ST_MRG_RD;
            end
         end
         ST_MRG_RD: begin
            if (k_ff >= hi_ff) begin
               lo_in    = XW'(hi_ff);
               state_in = ST_MRG_PAIR;
            end else begin
               cmd.rd_from_b = src_b_ff;
               rd_addr0      = a_ff[AW-1:0];
               rd_addr1      = b_ff[AW-1:0];
               state_in      = ST_MRG_WR;
            end
         end
         ST_MRG_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_to_b = !src_b_ff;
            wr_addr     = k_ff[AW-1:0];
            k_in        = k_p1;
            if (take_a) begin
               cmd.wr_src = hms_pkg::WR_RD0;
               a_in       = a_ff + CW'(1);
            end else begin
               cmd.wr_src = hms_pkg::WR_RD1;
               b_in       = b_ff + CW'(1);
            end
            state_in = ST_MRG_RD;
         end
         ST_EM_RD: begin
            if (!out_valid_ff) begin
               cmd.rd_from_b = src_b_ff;
               rd_addr0      = k_ff[AW-1:0];
               state_in      = ST_EM_LD;
            end
         end
         ST_EM_LD: begin
            cmd.out_load     = 1'b1;
            cmd.out_last     = (k_p1 == n_ff);
            cmd.out_overflow = ovf_ff;
            out_valid_in     = 1'b1;
            if (k_p1 == n_ff) begin
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_LOAD;
            end else begin
               k_in     = k_p1;
               state_in = ST_EM_RD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         src_b_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
         src_b_ff     <= src_b_in;
      end
      n_ff     <= n_in;
      lo_ff    <= lo_in;
      width_ff <= width_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      k_ff     <= k_in;
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_C)
      else $error("element count beyond store depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !out_valid_ff)
      else $error("result register loaded while a word is still pending");

   a_ins_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS_CMP) |-> (XW'(j_ff) > lo_ff))
      else $error("insertion scan ran below the start of its run");

   a_mrg_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MRG_WR) |-> ((a_ff < mid_ff) || (b_ff < hi_ff)))
      else $error("merge step with both runs exhausted");
`endif

endmodule

`default_nettype wire
